// File: src/spf_pkg.sv
// ----------------------------------------------------------------------------
// Smallest prime factor package
// Shared constants and the controller state type for the factor search.
// ----------------------------------------------------------------------------
package spf_pkg;

    // Default width of the number and of the returned factor.
    localparam int VALUE_BITS_DEF = 31;

    // Controller states, one-hot coded.
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DIV   = 4'b0010,
        S_CHECK = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

endpackage

// File: src/smallest_prime_factor.sv
// ----------------------------------------------------------------------------
// Smallest prime factor
// Finds the smallest prime factor of a positive integer by trial division
// over odd divisors, using a bit-serial restoring divider.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                  Payload
//  input     in         i_in_valid / o_in_ready    i_number
//  output    out        o_out_valid / i_out_ready  o_smallest_factor
//
// One, zero and even numbers skip the search and go straight to the done state.
// Each odd trial divisor goes through the bit-serial divider, which produces
// one quotient bit per cycle, and then through a check of the quotient and
// remainder. A prime near 2^31 takes about 23000 divisors.
// Reset is synchronous and active low; it clears the controller and the
// output valid. A new number is taken while a finished result still waits
// in the output register; a stalled output holds the next result back.

module smallest_prime_factor #(
    parameter int VALUE_BITS = spf_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [VALUE_BITS-1:0] i_number,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [VALUE_BITS-1:0] o_smallest_factor
);

    localparam int W  = VALUE_BITS;
    localparam int CW = $clog2(W);
    localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);
    localparam logic [W-1:0]  ONE      = W'(1);
    localparam logic [W-1:0]  TWO      = W'(2);
    localparam logic [W-1:0]  THREE    = W'(3);

    // Control registers.
    spf_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic [CW-1:0]   r_cnt, n_cnt;

    // Payload registers.
    logic [W-1:0] r_num, n_num;
    logic [W-1:0] r_shift, n_shift;
    logic [W-1:0] r_rem, n_rem;
    logic [W-1:0] r_quo, n_quo;
    logic [W-1:0] r_div, n_div;
    logic [W-1:0] r_result, n_result;
    logic [W-1:0] r_out_data, n_out_data;

    // Divider step: bring down the next dividend bit and try the divisor.
    logic [W:0] w_trial;
    logic [W:0] w_diff;
    logic       w_fits;

    assign w_trial = {r_rem, r_shift[W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    assign o_in_ready        = (r_state == spf_pkg::S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_smallest_factor = r_out_data;

    // Next-state logic for the controller and the datapath.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_cnt       = r_cnt;
        n_num       = r_num;
        n_shift     = r_shift;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_div       = r_div;
        n_result    = r_result;
        n_out_data  = r_out_data;

        // The consumer takes the waiting result.
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            spf_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_num   = i_number;
                    n_shift = i_number;
                    n_rem   = '0;
                    n_quo   = '0;
                    n_cnt   = '0;
                    n_div   = THREE;
                    if (i_number == ONE) begin
                        n_result = ONE;
                        n_state  = spf_pkg::S_DONE;
                    end else if (!i_number[0]) begin
                        n_result = TWO;
                        n_state  = spf_pkg::S_DONE;
                    end else begin
                        n_state = spf_pkg::S_DIV;
                    end
                end
            end
            spf_pkg::S_DIV: begin
                n_shift = {r_shift[W-2:0], 1'b0};
                n_quo   = {r_quo[W-2:0], w_fits};
                n_rem   = w_fits ? w_diff[W-1:0] : w_trial[W-1:0];
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = spf_pkg::S_CHECK;
                end
            end
            spf_pkg::S_CHECK: begin
                // Divisor above the quotient means no factor up to the root.
                if (r_div > r_quo) begin
                    n_result = r_num;
                    n_state  = spf_pkg::S_DONE;
                end else if (r_rem == '0) begin
                    n_result = r_div;
                    n_state  = spf_pkg::S_DONE;
                end else begin
                    n_div   = r_div + TWO;
                    n_shift = r_num;
                    n_rem   = '0;
                    n_quo   = '0;
                    n_cnt   = '0;
                    n_state = spf_pkg::S_DIV;
                end
            end
            spf_pkg::S_DONE: begin
                // Move the result into the output register once it is free.
                if (!r_out_valid || i_out_ready) begin
                    n_out_data  = r_result;
                    n_out_valid = 1'b1;
                    n_state     = spf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = spf_pkg::S_IDLE;
            end
        endcase
    end

    // Control state with synchronous reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spf_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_num      <= n_num;
        r_shift    <= n_shift;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_div      <= n_div;
        r_result   <= n_result;
        r_out_data <= n_out_data;
    end

    // A delivered factor is never zero.
    a_factor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_smallest_factor != '0))
        else $error("smallest_prime_factor: zero factor delivered");

    // Trial divisors stay odd during the search.
    a_div_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == spf_pkg::S_DIV) |-> r_div[0])
        else $error("smallest_prime_factor: even trial divisor");

    // The test of a divisor follows a completed division.
    a_check_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == spf_pkg::S_DIV) && (r_cnt == CNT_LAST) |=>
        (r_state == spf_pkg::S_CHECK))
        else $error("smallest_prime_factor: division did not end in a check");

endmodule

// File: verif/smallest_prime_factor_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Smallest prime factor testbench
// Sends directed and random numbers through the trial-division block with
// random idle gaps on the input and random stalls on the output, predicts
// each smallest prime factor in a scoreboard and checks every result in order.
// ----------------------------------------------------------------------------

module smallest_prime_factor_test;

    localparam int          VALUE_BITS   = spf_pkg::VALUE_BITS_DEF;
    localparam int unsigned MAX_VALUE    = (32'd1 << VALUE_BITS) - 1;
    localparam int          RANDOM_ITEMS = 80;
    localparam int          DRAIN_CYCLES = 50;
    // The largest prime is the slowest case; leave a wide margin.
    localparam int          CYCLE_LIMIT  = 5_000_000;

    typedef logic [VALUE_BITS-1:0] t_value;

    // Keeps the predicted factors of accepted numbers and checks each result.
    class factor_scoreboard;
        t_value      pending_factors[$];
        int unsigned fail_count;

        function new();
            fail_count = 0;
        endfunction

        // Trial division over odd divisors, bounded so the square never overflows.
        function t_value smallest_factor_of(t_value n);
            longint unsigned v;
            longint unsigned d;
            v = n;
            if (v == 1) return t_value'(1);
            if (v[0] == 1'b0) return t_value'(2);
            for (d = 3; d <= v / d; d += 2) begin
                if (v % d == 0) return t_value'(d);
            end
            return n;
        endfunction

        function void note_number(t_value n);
            pending_factors.push_back(smallest_factor_of(n));
        endfunction

        function void check_factor(t_value got);
            t_value expected;
            if (pending_factors.size() == 0) begin
                $error("smallest_factor: no transaction pending, actual %0d", got);
                fail_count++;
                return;
            end
            expected = pending_factors.pop_front();
            if (got !== expected) begin
                $error("smallest_factor: expected %0d, actual %0d", expected, got);
                fail_count++;
            end
        endfunction
    endclass

    logic   i_clk;
    logic   i_rst_n;
    logic   i_in_valid;
    logic   o_in_ready;
    t_value i_number;
    logic   o_out_valid;
    logic   i_out_ready;
    t_value o_smallest_factor;

    factor_scoreboard sb = new();
    int               cycle_count = 0;
    bit               gapless = 1'b0;

    // Extremes, the special cases and a few cheap primes and prime squares.
    t_value directed_numbers [0:19] = '{
        31'd0,          // zero takes the even rule
        31'd1,          // one answers itself
        31'd2, 31'd3, 31'd4, 31'd5,
        31'd9, 31'd25, 31'd49,       // prime squares hit the divisor bound exactly
        31'd15, 31'd97, 31'd4095,
        31'd65537, 31'd1000003,      // primes
        31'd1042441,                 // square of the prime 1021
        31'd1073741824,              // single high bit
        31'd1431655765,              // alternating bits
        31'd2147483645,
        31'd2147483646,              // largest even number
        31'd2147483647               // largest value, a prime: the slowest case
    };

    smallest_prime_factor u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_number          (i_number),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_smallest_factor (o_smallest_factor)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Run limit in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Transaction monitor on both channels.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.note_number(i_number);
            if (o_out_valid && i_out_ready) sb.check_factor(o_smallest_factor);
        end
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Random numbers kept cheap to factor: small values, some medium ones,
    // wide even values and wide products with a small odd factor.
    function automatic t_value random_number();
        int          r;
        int unsigned p;
        int unsigned m;
        t_value      n;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            n = t_value'($urandom_range(1, 4095));
        end else if (r < 50) begin
            n = t_value'($urandom_range(4096, 1 << 20));
        end else if (r < 75) begin
            n = t_value'($urandom());
            n[0] = 1'b0;
        end else begin
            p = 2 * $urandom_range(1, 49) + 1;
            m = $urandom_range(1, MAX_VALUE / p);
            n = t_value'(p * m);
        end
        return n;
    endfunction

    // Drive one number, wait for its transaction, then idle for a random gap, if any.
    task automatic send_number(input t_value n);
        int gap;
        i_in_valid <= 1'b1;
        i_number   <= n;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        gap = gapless ? 0 : idle_cycles();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Output side: ready stretches of random length broken by stalls.
    initial begin
        int run;
        int gap;
        i_out_ready = 1'b0;
        @(negedge i_clk);
        forever begin
            run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 8);
            i_out_ready <= 1'b1;
            repeat (run) @(negedge i_clk);
            gap = idle_cycles();
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    end

    // Main sequence: reset, directed numbers, random numbers, drain.
    initial begin
        int k;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_number   = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_numbers[i]) send_number(directed_numbers[i]);

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 10 == 0) gapless = ($urandom_range(0, 3) == 0);
            send_number(random_number());
        end
        i_in_valid <= 1'b0;

        while (sb.pending_factors.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
